FILE: rtl/adst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the advertising-data structure tokenizer.
package adst_pkg;

    localparam int unsigned ADST_MAX_PAYLOAD = 62;

    // Parse phase of the record walker
    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_TYPE  = 2'd1,
        PH_VALUE = 2'd2,
        PH_DONE  = 2'd3
    } t_adst_phase;

    // Role of one payload byte
    typedef enum logic [3:0] {
        ROLE_LEN        = 4'd0,
        ROLE_TYPE       = 4'd1,
        ROLE_NAME       = 4'd2,
        ROLE_TXPOWER    = 4'd3,
        ROLE_APPEARANCE = 4'd4,
        ROLE_FLAGS      = 4'd5,
        ROLE_UUID16     = 4'd6,
        ROLE_UUID32     = 4'd7,
        ROLE_UUID128    = 4'd8,
        ROLE_MFR        = 4'd9,
        ROLE_SVCUUID    = 4'd10,
        ROLE_SVCDATA    = 4'd11,
        ROLE_IGNORED    = 4'd12,
        ROLE_OUTSIDE    = 4'd13
    } t_adst_role;

    // AD type codes
    localparam logic [7:0] AD_FLAGS          = 8'h01;
    localparam logic [7:0] AD_UUID16_INC     = 8'h02;
    localparam logic [7:0] AD_UUID16_CMP     = 8'h03;
    localparam logic [7:0] AD_UUID32_INC     = 8'h04;
    localparam logic [7:0] AD_UUID32_CMP     = 8'h05;
    localparam logic [7:0] AD_UUID128_INC    = 8'h06;
    localparam logic [7:0] AD_UUID128_CMP    = 8'h07;
    localparam logic [7:0] AD_NAME           = 8'h09;
    localparam logic [7:0] AD_TXPOWER        = 8'h0A;
    localparam logic [7:0] AD_SVCDATA16      = 8'h16;
    localparam logic [7:0] AD_APPEARANCE     = 8'h19;
    localparam logic [7:0] AD_SVCDATA32      = 8'h20;
    localparam logic [7:0] AD_SVCDATA128     = 8'h21;
    localparam logic [7:0] AD_MFR            = 8'hFF;

    // One input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic [5:0] payload_length;
        logic       packet_start;
    } t_adst_item;

    // Value-byte tag from the tagger
    typedef struct packed {
        t_adst_role role;
        logic [5:0] idx;
        logic       done;
    } t_adst_tag;

    // One result beat
    typedef struct packed {
        logic [7:0] tagged_byte;
        t_adst_role byte_role;
        logic [7:0] record_kind;
        logic [5:0] element_byte_index;
        logic       element_done;
        logic       record_cut;
        logic       packet_end;
    } t_adst_result;

endpackage

FILE: rtl/adst_value_tagger.sv
`timescale 1ns / 1ps
// Tags one value byte from the record's AD type, value length and offset.
module adst_value_tagger (
    input  logic [7:0]         i_kind,
    input  logic [7:0]         i_vlen,
    input  logic [7:0]         i_off,
    output adst_pkg::t_adst_tag o_tag
);
    import adst_pkg::*;

    logic [8:0] off_p1;
    logic       last;

    // Service data: UUID of the given size, then data to end of value
    function automatic t_adst_tag svc_tag(input logic [7:0] vlen, input logic [7:0] off,
                                          input logic [7:0] usize, input logic last_b);
        t_adst_tag t;
        t.role = ROLE_IGNORED;
        t.idx  = '0;
        t.done = 1'b0;
        if (vlen >= usize) begin
            if (off < usize) begin
                t.role = ROLE_SVCUUID;
                t.idx  = off[5:0];
                t.done = (off == usize - 8'd1);
            end else begin
                t.role = ROLE_SVCDATA;
                t.idx  = 6'(off - usize);
                t.done = last_b;
            end
        end
        return t;
    endfunction

    assign off_p1 = {1'b0, i_off} + 9'd1;
    assign last   = (off_p1 == {1'b0, i_vlen});

    always_comb begin
        o_tag.role = ROLE_IGNORED;
        o_tag.idx  = '0;
        o_tag.done = 1'b0;
        case (i_kind) inside
            AD_NAME: begin
                o_tag.role = ROLE_NAME;
                o_tag.idx  = i_off[5:0];
                o_tag.done = last;
            end
            AD_MFR: begin
                o_tag.role = ROLE_MFR;
                o_tag.idx  = i_off[5:0];
                o_tag.done = last;
            end
            AD_TXPOWER: begin
                if (i_off == 8'd0) begin
                    o_tag.role = ROLE_TXPOWER;
                    o_tag.done = 1'b1;
                end
            end
            AD_FLAGS: begin
                if (i_off == 8'd0) begin
                    o_tag.role = ROLE_FLAGS;
                    o_tag.done = 1'b1;
                end
            end
            AD_APPEARANCE: begin
                if (i_vlen >= 8'd2 && i_off < 8'd2) begin
                    o_tag.role = ROLE_APPEARANCE;
                    o_tag.idx  = i_off[5:0];
                    o_tag.done = (i_off == 8'd1);
                end
            end
            AD_UUID16_INC, AD_UUID16_CMP: begin
                if (i_off < {i_vlen[7:1], 1'b0}) begin
                    o_tag.role = ROLE_UUID16;
                    o_tag.idx  = {5'd0, i_off[0]};
                    o_tag.done = i_off[0];
                end
            end
            AD_UUID32_INC, AD_UUID32_CMP: begin
                if (i_off < {i_vlen[7:2], 2'b0}) begin
                    o_tag.role = ROLE_UUID32;
                    o_tag.idx  = {4'd0, i_off[1:0]};
                    o_tag.done = &i_off[1:0];
                end
            end
            AD_UUID128_INC, AD_UUID128_CMP: begin
                if (i_off < {i_vlen[7:4], 4'b0}) begin
                    o_tag.role = ROLE_UUID128;
                    o_tag.idx  = {2'd0, i_off[3:0]};
                    o_tag.done = &i_off[3:0];
                end
            end
            AD_SVCDATA16:  o_tag = svc_tag(i_vlen, i_off, 8'd2, last);
            AD_SVCDATA32:  o_tag = svc_tag(i_vlen, i_off, 8'd4, last);
            AD_SVCDATA128: o_tag = svc_tag(i_vlen, i_off, 8'd16, last);
            default: ;
        endcase
    end

endmodule

FILE: rtl/adst_parser.sv
`timescale 1ns / 1ps
// Record walker: parse state and per-byte result for one registered beat.
module adst_parser #(
    parameter int unsigned MAX_PAYLOAD_BYTES = adst_pkg::ADST_MAX_PAYLOAD
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  adst_pkg::t_adst_item    i_item,
    output adst_pkg::t_adst_result  o_result
);
    import adst_pkg::*;

    localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD_BYTES);

    logic [5:0]  r_pos,   n_pos;
    t_adst_phase r_phase, n_phase;
    logic [7:0]  r_kind,  n_kind;
    logic [7:0]  r_vlen,  n_vlen;
    logic [7:0]  r_off,   n_off;

    logic [5:0]  pos;
    t_adst_phase phase;
    logic [5:0]  len;
    logic [8:0]  off_p1;
    t_adst_tag   vtag;

    adst_value_tagger u_tagger (
        .i_kind (r_kind),
        .i_vlen (r_vlen),
        .i_off  (r_off),
        .o_tag  (vtag)
    );

    // start mark restarts position and phase before the byte is handled
    assign pos    = i_item.packet_start ? 6'd0 : r_pos;
    assign phase  = i_item.packet_start ? PH_LEN : r_phase;
    assign len    = ({2'b0, i_item.payload_length} > MaxLen) ? MaxLen[5:0]
                                                              : i_item.payload_length;
    assign off_p1 = {1'b0, r_off} + 9'd1;

    always_comb begin
        n_phase = phase;
        n_kind  = r_kind;
        n_vlen  = r_vlen;
        n_off   = r_off;
        n_pos   = (pos != 6'd63) ? pos + 6'd1 : pos;

        o_result.tagged_byte        = i_item.data_byte;
        o_result.byte_role          = ROLE_OUTSIDE;
        o_result.record_kind        = '0;
        o_result.element_byte_index = '0;
        o_result.element_done       = 1'b0;
        o_result.record_cut         = 1'b0;
        o_result.packet_end         = 1'b0;

        if (pos < len) begin
            o_result.packet_end = ({1'b0, pos} + 7'd1 == {1'b0, len});
            unique case (phase)
                PH_LEN: begin
                    if ({1'b0, pos} + 7'd2 < {1'b0, len}) begin
                        o_result.byte_role = ROLE_LEN;
                        if (i_item.data_byte == 8'd0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_vlen  = i_item.data_byte - 8'd1;
                            n_phase = PH_TYPE;
                        end
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_TYPE: begin
                    o_result.byte_role   = ROLE_TYPE;
                    o_result.record_kind = i_item.data_byte;
                    n_kind  = i_item.data_byte;
                    n_off   = '0;
                    n_phase = (r_vlen == 8'd0) ? PH_LEN : PH_VALUE;
                end
                PH_VALUE: begin
                    o_result.record_kind        = r_kind;
                    o_result.byte_role          = vtag.role;
                    o_result.element_byte_index = vtag.idx;
                    o_result.element_done       = vtag.done;
                    o_result.record_cut = o_result.packet_end && (off_p1 < {1'b0, r_vlen});
                    n_off = off_p1[7:0];
                    if (off_p1[7:0] >= r_vlen) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
        end else begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_LEN;
            r_kind  <= '0;
            r_vlen  <= '0;
            r_off   <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_vlen  <= n_vlen;
            r_off   <= n_off;
        end
    end

endmodule

FILE: rtl/ad_structure_tokenizer.sv
`timescale 1ns / 1ps
// Top level: advertising-data structure tokenizer with input and result registers.
//
//  Channel | Dir | Beat                     | Fields
//  --------+-----+--------------------------+----------------------------------------------
//  s       | in  | i_s_tvalid & o_s_tready  | tdata: byte, length; tuser: packet start
//  m       | out | o_m_tvalid & i_m_tready  | tdata: byte; tuser: role, kind, idx, done, cut;
//          |     |                          | tlast: packet end
//
// One beat per cycle sustained while i_m_tready stays high. Each beat passes an input register, then
// the record walker and value tagger feeding the result register.
// Reset (i_rst_n low at a clock edge) empties both registers and returns the
// walker to expect a length byte at position 0.
// A stalled result holds in the output register while the input register still
// takes one more beat; tready falls only when both are full.
module ad_structure_tokenizer #(
    parameter int unsigned MAX_PAYLOAD_BYTES = adst_pkg::ADST_MAX_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] data_byte, [13:8] payload_length, [15:14] zero
    input  logic        i_s_tuser,   // [0] packet_start
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] tagged_byte
    output logic [19:0] o_m_tuser,   // [3:0] byte_role, [11:4] record_kind,
                                     // [17:12] element_byte_index, [18] element_done,
                                     // [19] record_cut
    output logic        o_m_tlast    // packet_end
);
    import adst_pkg::*;

    logic         r_s1_valid;
    t_adst_item   r_s1_item;
    logic         r_out_valid;
    t_adst_result r_out;

    logic         out_ready;
    logic         s1_ready;
    logic         step;
    t_adst_result result;

    assign out_ready  = !r_out_valid || i_m_tready;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign step       = r_s1_valid && out_ready;
    assign o_s_tready = s1_ready;

    adst_parser #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_s1_item),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_s_tvalid) begin
            r_s1_item.data_byte      <= i_s_tdata[7:0];
            r_s1_item.payload_length <= i_s_tdata[13:8];
            r_s1_item.packet_start   <= i_s_tuser;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.tagged_byte;
    assign o_m_tuser  = {r_out.record_cut, r_out.element_done, r_out.element_byte_index,
                         r_out.record_kind, r_out.byte_role};
    assign o_m_tlast  = r_out.packet_end;

    // cut is only flagged on the last payload byte
    a_cut_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.record_cut |-> r_out.packet_end)
        else $error("record_cut without packet_end");

    // element completion only on value roles
    a_done_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.element_done |->
            r_out.byte_role != ROLE_LEN && r_out.byte_role != ROLE_TYPE &&
            r_out.byte_role != ROLE_IGNORED && r_out.byte_role != ROLE_OUTSIDE)
        else $error("element_done on non-value byte");

    // a type byte reports itself as the record kind
    a_type_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.byte_role == ROLE_TYPE |-> r_out.record_kind == r_out.tagged_byte)
        else $error("type byte kind mismatch");

    // empty result register never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_tready)
        else $error("input stalled with empty result register");

endmodule
